@@ design/convex_polygon_overlap_test_defines.svh @@
// assertion macros for the convex polygon overlap test
`ifndef CONVEX_POLYGON_OVERLAP_TEST_DEFINES_SVH
`define CONVEX_POLYGON_OVERLAP_TEST_DEFINES_SVH
`ifndef SYNTHESIS
`define CPOT_ASSERT_IMP(label, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define CPOT_ASSERT_NXT(label, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define CPOT_ASSERT_IMP(label, rst_n, a, c)
`define CPOT_ASSERT_NXT(label, rst_n, a, c)
`endif
`endif

@@ design/cpot_pkg.sv @@
// ---------------------------------------------------------------------------
// cpot_pkg
// shared types and constants of the convex polygon overlap test
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package cpot_pkg;
  localparam int MAX_CORNERS = 16;
  localparam int MIN_CORNERS = 3;
  localparam int IDX_W = $clog2(MAX_CORNERS);
  localparam int CNT_W = $clog2(MAX_CORNERS + 1);
  localparam int SUM_W = 16 + CNT_W;

  localparam logic [1:0] CMD_ADD_A = 2'd0;
  localparam logic [1:0] CMD_ADD_B = 2'd1;
  localparam logic [1:0] CMD_EVAL  = 2'd2;

  typedef struct packed {
    logic             load;     // store the input corner
    logic             poly_sel; // 0 polygon a, 1 polygon b
    logic             clr;      // clear counts and overflow flag
    logic             sum_clr;  // clear centroid accumulators
    logic             sum_acc;  // accumulate corner sel side at sidx
    logic             side_rd;  // read side corners i and i+1
    logic             side_ld;  // latch side corners, build d
    logic             v_ld;     // build v
    logic             sv_mul;   // multiply cross(v,d) products
    logic             sv_ld;    // register sign of cross(v,d)
    logic             pt_rd;    // read test corner
    logic             w_ld;     // build w
    logic             pw_mul;   // multiply cross(w,d) products
    logic             pw_ld;    // register sign of cross(w,d)
    logic [IDX_W-1:0] sidx;
    logic [IDX_W-1:0] pidx;
  } cpot_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt_a;
    logic [CNT_W-1:0] cnt_b;
    logic             ovf;
    logic             d_zero;
    logic [1:0]       sv;     // 01 positive, 11 negative, 00 zero
    logic [1:0]       sw;
  } cpot_sts_t;
endpackage

@@ design/cpot_datapath.sv @@
// ---------------------------------------------------------------------------
// cpot_datapath
// corner stores, centroid sums and the cross product sign unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module cpot_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  cpot_pkg::cpot_cmd_t cmd,
  input  logic signed [15:0]  corner_x,
  input  logic signed [15:0]  corner_y,
  output cpot_pkg::cpot_sts_t sts
);
  import cpot_pkg::*;

  logic signed [15:0] ax_mem [MAX_CORNERS];
  logic signed [15:0] ay_mem [MAX_CORNERS];
  logic signed [15:0] bx_mem [MAX_CORNERS];
  logic signed [15:0] by_mem [MAX_CORNERS];

  logic [CNT_W-1:0] cnt_a_r, cnt_b_r;
  logic             ovf_r;

  logic signed [15:0] s0x_r, s0y_r, s1x_r, s1y_r, px_r, py_r;
  logic signed [SUM_W-1:0] sumx_r, sumy_r;
  logic signed [16:0] dx_r, dy_r, wx_r, wy_r;
  logic signed [SUM_W+1:0] vx_r, vy_r;
  logic signed [SUM_W+18:0] pa_r, pb_r;
  logic signed [SUM_W+19:0] diff;
  logic [1:0] sv_r, sw_r;

  logic [IDX_W-1:0] nidx;
  logic [CNT_W-1:0] scnt;

  assign scnt = cmd.poly_sel ? cnt_b_r : cnt_a_r;
  assign nidx = ({1'b0, cmd.sidx} + 1'b1 == {1'b0, scnt}) ? '0 : cmd.sidx + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.clr) begin
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load) begin
      if (!cmd.poly_sel) begin
        if (cnt_a_r < CNT_W'(MAX_CORNERS)) cnt_a_r <= cnt_a_r + 1'b1;
        else ovf_r <= 1'b1;
      end else begin
        if (cnt_b_r < CNT_W'(MAX_CORNERS)) cnt_b_r <= cnt_b_r + 1'b1;
        else ovf_r <= 1'b1;
      end
    end
  end

  // stores: sel names the side polygon, test corners come from the other
  always_ff @(posedge clk) begin
    if (cmd.load && !cmd.poly_sel && cnt_a_r < CNT_W'(MAX_CORNERS)) begin
      ax_mem[cnt_a_r[IDX_W-1:0]] <= corner_x;
      ay_mem[cnt_a_r[IDX_W-1:0]] <= corner_y;
    end
    if (cmd.load && cmd.poly_sel && cnt_b_r < CNT_W'(MAX_CORNERS)) begin
      bx_mem[cnt_b_r[IDX_W-1:0]] <= corner_x;
      by_mem[cnt_b_r[IDX_W-1:0]] <= corner_y;
    end
    if (cmd.side_rd || cmd.sum_acc) begin
      s0x_r <= cmd.poly_sel ? bx_mem[cmd.sidx] : ax_mem[cmd.sidx];
      s0y_r <= cmd.poly_sel ? by_mem[cmd.sidx] : ay_mem[cmd.sidx];
      s1x_r <= cmd.poly_sel ? bx_mem[nidx] : ax_mem[nidx];
      s1y_r <= cmd.poly_sel ? by_mem[nidx] : ay_mem[nidx];
    end
    if (cmd.pt_rd) begin
      px_r <= cmd.poly_sel ? ax_mem[cmd.pidx] : bx_mem[cmd.pidx];
      py_r <= cmd.poly_sel ? ay_mem[cmd.pidx] : by_mem[cmd.pidx];
    end
  end

  // sum_acc reads the corner, the delayed acc_d_r adds it the next cycle
  logic acc_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) acc_d_r <= 1'b0;
    else acc_d_r <= cmd.sum_acc;
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      sumx_r <= '0;
      sumy_r <= '0;
    end else if (acc_d_r) begin
      sumx_r <= sumx_r + SUM_W'(s0x_r);
      sumy_r <= sumy_r + SUM_W'(s0y_r);
    end
    if (cmd.side_ld) begin
      dx_r <= 17'(s1x_r) - 17'(s0x_r);
      dy_r <= 17'(s1y_r) - 17'(s0y_r);
    end
    if (cmd.v_ld) begin
      vx_r <= (SUM_W+2)'($signed({1'b0, scnt}) * s0x_r) - (SUM_W+2)'(sumx_r);
      vy_r <= (SUM_W+2)'($signed({1'b0, scnt}) * s0y_r) - (SUM_W+2)'(sumy_r);
    end
    if (cmd.w_ld) begin
      wx_r <= 17'(px_r) - 17'(s0x_r);
      wy_r <= 17'(py_r) - 17'(s0y_r);
    end
    if (cmd.sv_mul) begin
      pa_r <= (SUM_W+19)'(vx_r * dy_r);
      pb_r <= (SUM_W+19)'(vy_r * dx_r);
    end else if (cmd.pw_mul) begin
      pa_r <= (SUM_W+19)'(wx_r * dy_r);
      pb_r <= (SUM_W+19)'(wy_r * dx_r);
    end
  end

  assign diff = (SUM_W+20)'(pa_r) - (SUM_W+20)'(pb_r);

  always_ff @(posedge clk) begin
    if (cmd.sv_ld) sv_r <= {diff[SUM_W+19], diff != '0};
    if (cmd.pw_ld) sw_r <= {diff[SUM_W+19], diff != '0};
  end

  assign sts.cnt_a  = cnt_a_r;
  assign sts.cnt_b  = cnt_b_r;
  assign sts.ovf    = ovf_r;
  assign sts.d_zero = (dx_r == '0) && (dy_r == '0);
  assign sts.sv     = sv_r;
  assign sts.sw     = sw_r;
endmodule

@@ design/cpot_ctrl.sv @@
// ---------------------------------------------------------------------------
// cpot_ctrl
// sequencer of loads and the side by corner evaluation walk
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module cpot_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_intersecting,
  output logic                out_too_few_corners,
  output logic                out_corner_overflow,
  output cpot_pkg::cpot_cmd_t cmd,
  input  cpot_pkg::cpot_sts_t sts
);
  import cpot_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;
  localparam logic [3:0] S_SUMW  = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SLD   = 4'd4;
  localparam logic [3:0] S_V     = 4'd5;
  localparam logic [3:0] S_VMUL  = 4'd6;
  localparam logic [3:0] S_VSGN  = 4'd7;
  localparam logic [3:0] S_PRD   = 4'd8;
  localparam logic [3:0] S_W     = 4'd9;
  localparam logic [3:0] S_WMUL  = 4'd10;
  localparam logic [3:0] S_WSGN  = 4'd11;
  localparam logic [3:0] S_CHK   = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0]       state_r, state_nxt;
  logic             sel_r, sel_nxt;
  logic             sep_r, sep_nxt;
  logic [IDX_W-1:0] sidx_r, sidx_nxt, pidx_r, pidx_nxt;
  logic             ov_r, ov_nxt;
  logic             oi_r, oi_nxt, of_r, of_nxt, oo_r, oo_nxt;
  logic [CNT_W-1:0] scnt, pcnt;
  logic             few, s_last, p_last;

  assign scnt   = sel_r ? sts.cnt_b : sts.cnt_a;
  assign pcnt   = sel_r ? sts.cnt_a : sts.cnt_b;
  assign s_last = {1'b0, sidx_r} + 1'b1 == {1'b0, scnt};
  assign p_last = {1'b0, pidx_r} + 1'b1 == {1'b0, pcnt};
  assign few    = sts.cnt_a < CNT_W'(MIN_CORNERS) || sts.cnt_b < CNT_W'(MIN_CORNERS);

  assign in_stall = (state_r != S_IDLE) || (ov_r && out_stall);

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    sep_nxt   = sep_r;
    sidx_nxt  = sidx_r;
    pidx_nxt  = pidx_r;
    ov_nxt    = ov_r && out_stall;
    oi_nxt    = oi_r;
    of_nxt    = of_r;
    oo_nxt    = oo_r;
    cmd       = '0;
    cmd.poly_sel = sel_r;
    cmd.sidx  = sidx_r;
    cmd.pidx  = pidx_r;
    case (state_r)
      S_IDLE: begin
        cmd.poly_sel = in_command[0];
        if (in_valid && !in_stall) begin
          if (in_command inside {CMD_ADD_A, CMD_ADD_B}) begin
            cmd.load = 1'b1;
          end else if (in_command == CMD_EVAL) begin
            if (few) begin
              ov_nxt = 1'b1;
              oi_nxt = 1'b0;
              of_nxt = 1'b1;
              oo_nxt = sts.ovf;
              cmd.clr = 1'b1;
            end else begin
              sel_nxt   = 1'b0;
              sep_nxt   = 1'b0;
              sidx_nxt  = '0;
              state_nxt = S_SUM;
              cmd.sum_clr = 1'b1;
            end
          end
        end
      end
      S_SUM: begin
        cmd.sum_acc = 1'b1;
        if (s_last) begin
          sidx_nxt  = '0;
          state_nxt = S_SUMW;
        end else sidx_nxt = sidx_r + 1'b1;
      end
      S_SUMW: state_nxt = S_SRD;
      S_SRD: begin
        cmd.side_rd = 1'b1;
        state_nxt = S_SLD;
      end
      S_SLD: begin
        cmd.side_ld = 1'b1;
        cmd.v_ld    = 1'b1;
        state_nxt = S_V;
      end
      S_V: begin
        if (sts.d_zero) state_nxt = S_CHK;
        else begin
          cmd.sv_mul = 1'b1;
          state_nxt = S_VMUL;
        end
      end
      S_VMUL: begin
        cmd.sv_ld = 1'b1;
        state_nxt = S_VSGN;
      end
      S_VSGN: begin
        pidx_nxt = '0;
        state_nxt = (sts.sv[0]) ? S_PRD : S_CHK;
      end
      S_PRD: begin
        cmd.pt_rd = 1'b1;
        state_nxt = S_W;
      end
      S_W: begin
        cmd.w_ld = 1'b1;
        state_nxt = S_WMUL;
      end
      S_WMUL: begin
        cmd.pw_mul = 1'b1;
        state_nxt = S_WSGN;
      end
      S_WSGN: begin
        cmd.pw_ld = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // compare corner sign against side sign
        if (sts.sw != sts.sv) state_nxt = S_CHK;
        else if (p_last) begin
          sep_nxt = 1'b1;
          state_nxt = S_CHK;
        end else begin
          pidx_nxt = pidx_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_CHK: begin
        if (sep_r || s_last) begin
          if (sep_r || sel_r) begin
            ov_nxt = 1'b1;
            oi_nxt = !sep_r;
            of_nxt = 1'b0;
            oo_nxt = sts.ovf;
            cmd.clr = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            sel_nxt  = 1'b1;
            sidx_nxt = '0;
            cmd.sum_clr = 1'b1;
            state_nxt = S_SUM;
          end
        end else begin
          sidx_nxt = sidx_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      sel_r   <= 1'b0;
      sep_r   <= 1'b0;
      sidx_r  <= '0;
      pidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      sel_r   <= sel_nxt;
      sep_r   <= sep_nxt;
      sidx_r  <= sidx_nxt;
      pidx_r  <= pidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oi_r <= oi_nxt;
    of_r <= of_nxt;
    oo_r <= oo_nxt;
  end

  assign out_valid           = ov_r;
  assign out_intersecting    = oi_r;
  assign out_too_few_corners = of_r;
  assign out_corner_overflow = oo_r;
endmodule

@@ design/convex_polygon_overlap_test.sv @@
// ---------------------------------------------------------------------------
// convex_polygon_overlap_test
// separating axis overlap test of two convex polygons in q12.4
// ---------------------------------------------------------------------------
// corner beats (command 0 for polygon a, 1 for b) are taken one per cycle
// while no evaluation runs and no stalled result is waiting; up to 16
// corners per polygon are kept, extra ones are dropped and flagged. an
// evaluate beat walks the sides of each polygon until one separates them:
// centroid sums of the side polygon, a setup per side and a test of each
// corner of the other polygon, all through the single shared cross
// product unit and its two multipliers. an evaluate with fewer than three
// corners in either polygon answers the next cycle. one result beat per
// evaluate; the stores are cleared afterwards. command code 3 is ignored.
`timescale 1ns / 1ps
`include "convex_polygon_overlap_test_defines.svh"
module convex_polygon_overlap_test (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic signed [15:0] in_corner_x,
  input  logic signed [15:0] in_corner_y,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_intersecting,
  output logic              out_too_few_corners,
  output logic              out_corner_overflow
);
  import cpot_pkg::*;

  cpot_cmd_t cmd;
  cpot_sts_t sts;

  // controller: handshake and evaluation walk
  cpot_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_command,
    .out_valid, .out_stall, .out_intersecting, .out_too_few_corners,
    .out_corner_overflow, .cmd, .sts
  );

  // datapath: stores and sign unit
  cpot_datapath u_dp (
    .clk, .rst_n, .cmd, .corner_x(in_corner_x), .corner_y(in_corner_y), .sts
  );

  // a held result stays put while stalled
  `CPOT_ASSERT_NXT(a_out_hold, rst_n, out_valid && out_stall,
    out_valid && $stable(out_intersecting))
  // too few corners never reports an overlap
  `CPOT_ASSERT_IMP(a_few_no_hit, rst_n, out_valid && out_too_few_corners,
    !out_intersecting)
  // counts never pass capacity
  `CPOT_ASSERT_IMP(a_cnt_cap, rst_n, 1'b1,
    sts.cnt_a <= CNT_W'(MAX_CORNERS) && sts.cnt_b <= CNT_W'(MAX_CORNERS))
endmodule
